// ===== sv/ssr_pkg.sv =====
// Shared types and constants of the streaming find-and-replace block.
`timescale 1ns / 1ps
package ssr_pkg;

  localparam int ByteW    = 8;
  localparam int RunMax   = 8;   // bytes held by one 64-bit pattern or replacement register
  localparam int CntW     = 4;   // holds a byte count of 0 to RunMax
  localparam int IdxW     = 3;   // indexes one byte of a run
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 64;
  localparam int QDepth   = 4;   // runs held between front and back
  localparam int DefMaxPattern     = 8;
  localparam int DefMaxReplacement = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatternBytes     = 2'd0,
    CfgPatternLength    = 2'd1,
    CfgReplacementBytes = 2'd2,
    CfgReplacementLength = 2'd3
  } cfg_idx_e;

  // All result beats caused by one input beat.
  typedef struct packed {
    logic [RunMax-1:0][ByteW-1:0] bytes;  // first byte in entry 0
    logic [CntW-1:0]              count;  // zero only for the empty end marker
    logic                         eos;
  } run_t;

endpackage

// ===== sv/ssr_in_if.sv =====
// Input byte channel of the find-and-replace block.
`timescale 1ns / 1ps
interface ssr_in_if;
  logic                      valid;
  logic                      ready;
  logic [ssr_pkg::ByteW-1:0] data_byte;
  logic                      end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// ===== sv/ssr_out_if.sv =====
// Output byte channel of the find-and-replace block.
`timescale 1ns / 1ps
interface ssr_out_if;
  logic                      valid;
  logic                      ready;
  logic [ssr_pkg::ByteW-1:0] out_byte;
  logic                      byte_valid;
  logic                      run_last;
  logic                      stream_end;

  modport source (output valid, output out_byte, output byte_valid, output run_last,
                  output stream_end, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                  input stream_end, output ready);
endinterface

// ===== sv/ssr_front.sv =====
// Front end: configuration registers, match window and run classification.
`timescale 1ns / 1ps
module ssr_front #(
  parameter int MAX_PATTERN     = ssr_pkg::DefMaxPattern,
  parameter int MAX_REPLACEMENT = ssr_pkg::DefMaxReplacement
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ssr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ssr_pkg::CfgDataW-1:0] cfg_wdata_i,
  ssr_in_if.sink                       in_i,
  input  logic                         full_i,
  output logic                         push_o,
  output ssr_pkg::run_t                run_o
);

  localparam int WinDepth = (MAX_PATTERN < ssr_pkg::RunMax) ? MAX_PATTERN : ssr_pkg::RunMax;
  localparam int ReplLim  = (MAX_REPLACEMENT < ssr_pkg::RunMax) ? MAX_REPLACEMENT
                                                                 : ssr_pkg::RunMax;
  localparam int FillW    = (WinDepth > 1) ? $clog2(WinDepth) : 1;
  localparam logic [ssr_pkg::CntW-1:0] WinLen  = ssr_pkg::CntW'(WinDepth);
  localparam logic [ssr_pkg::CntW-1:0] ReplLen = ssr_pkg::CntW'(ReplLim);

  logic [ssr_pkg::CfgDataW-1:0] pat_q, repl_q;
  logic [ssr_pkg::CntW-1:0]     plen_q, rlen_q;
  logic [WinDepth-1:0][ssr_pkg::ByteW-1:0] win_q, win_d, win_app, win_sh;
  logic [ssr_pkg::RunMax-1:0][ssr_pkg::ByteW-1:0] win_ext;
  logic [FillW-1:0]         fill_q, fill_d;
  logic [ssr_pkg::CntW-1:0] fill_ext, fill_inc, plen, rlen;
  logic                     accept, stale, full_now, match, hit_now;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;

  assign plen = (plen_q == '0) ? ssr_pkg::CntW'(1) : ((plen_q > WinLen) ? WinLen : plen_q);
  assign rlen = (rlen_q > ReplLen) ? ReplLen : rlen_q;

  assign fill_ext = ssr_pkg::CntW'(fill_q);
  assign fill_inc = fill_ext + ssr_pkg::CntW'(1);
  // A shorter pattern written while bytes were held leaves a stale window.
  assign stale    = fill_ext >= plen;
  assign full_now = !stale && (fill_inc == plen);

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < WinDepth; i++) begin
      win_app[i] = (fill_q == FillW'(i)) ? in_i.data_byte : win_q[i];
      if ((ssr_pkg::CntW'(i) < plen) &&
          (win_app[i] != pat_q[ssr_pkg::ByteW*i +: ssr_pkg::ByteW])) begin
        match = 1'b0;
      end
    end
    for (int i = 0; i < WinDepth - 1; i++) begin
      win_sh[i] = win_app[i+1];
    end
    win_sh[WinDepth-1] = '0;
  end

  assign hit_now = full_now && match;

  for (genvar g = 0; g < ssr_pkg::RunMax; g++) begin : g_ext
    if (g < WinDepth) begin : g_win
      assign win_ext[g] = win_app[g];
    end else begin : g_zero
      assign win_ext[g] = '0;
    end
  end

  always_comb begin
    run_o.eos   = in_i.end_of_stream;
    run_o.bytes = win_ext;
    run_o.count = '0;
    win_d       = win_app;
    fill_d      = fill_q;
    if (hit_now) begin
      run_o.bytes = repl_q;
      run_o.count = rlen;
      fill_d      = '0;
    end else if (stale || in_i.end_of_stream) begin
      // Release every held byte and the new one.
      run_o.count = fill_inc;
      fill_d      = '0;
    end else if (full_now) begin
      // Mismatch: the oldest byte leaves, the fill stays at pattern length minus one.
      run_o.count = ssr_pkg::CntW'(1);
      win_d       = win_sh;
    end else begin
      fill_d = FillW'(fill_inc);
    end
  end

  assign push_o = accept && ((run_o.count != '0) || in_i.end_of_stream);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      plen_q <= ssr_pkg::CntW'(1);
      repl_q <= '0;
      rlen_q <= '0;
      fill_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (ssr_pkg::cfg_idx_e'(cfg_index_i))
          ssr_pkg::CfgPatternBytes:      pat_q  <= cfg_wdata_i;
          ssr_pkg::CfgPatternLength:     plen_q <= cfg_wdata_i[ssr_pkg::CntW-1:0];
          ssr_pkg::CfgReplacementBytes:  repl_q <= cfg_wdata_i;
          ssr_pkg::CfgReplacementLength: rlen_q <= cfg_wdata_i[ssr_pkg::CntW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        fill_q <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q <= win_d;
    end
  end

endmodule

// ===== sv/ssr_queue.sv =====
// Short queue of runs between the front end and the back end.
`timescale 1ns / 1ps
module ssr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ssr_pkg::run_t run_i,
  input  logic          pop_i,
  output logic          valid_o,
  output logic          full_o,
  output ssr_pkg::run_t head_o
);

  localparam int PtrW = $clog2(ssr_pkg::QDepth);
  localparam int CntQW = $clog2(ssr_pkg::QDepth + 1);

  ssr_pkg::run_t mem_q [ssr_pkg::QDepth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntQW-1:0] cnt_q;

  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == CntQW'(ssr_pkg::QDepth);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntQW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntQW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= run_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && full_o |-> pop_i == 1'b0 ? 1'b0 : 1'b1)
    else $error("run pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("run popped from an empty queue");

endmodule

// ===== sv/ssr_back.sv =====
// Back end: sends the bytes of each queued run, one beat per cycle while the output is ready.
`timescale 1ns / 1ps
module ssr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  ssr_pkg::run_t head_i,
  output logic          pop_o,
  ssr_out_if.source     out_o
);

  logic [ssr_pkg::IdxW-1:0] idx_q, idx_d;
  logic last, fire, has_byte;

  assign has_byte = head_i.count != '0;
  assign last     = !has_byte ||
                    (ssr_pkg::CntW'(idx_q) == (head_i.count - ssr_pkg::CntW'(1)));

  assign out_o.valid      = head_valid_i;
  assign out_o.byte_valid = has_byte;
  assign out_o.out_byte   = has_byte ? head_i.bytes[idx_q] : '0;
  assign out_o.run_last   = last;
  assign out_o.stream_end = last && head_i.eos;

  assign fire  = out_o.valid && out_o.ready;
  assign pop_o = fire && last;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = last ? '0 : idx_q + ssr_pkg::IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  a_empty_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i && !has_byte |-> head_i.eos)
    else $error("empty run that does not end a stream");
  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i && has_byte |-> ssr_pkg::CntW'(idx_q) < head_i.count)
    else $error("byte index beyond run length");
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !last |=> out_o.valid && (idx_q != '0))
    else $error("run interrupted before its last beat");

endmodule

// ===== sv/stream_substring_replace.sv =====
// Top level of the streaming find-and-replace block.
// Throughput: one input beat per cycle while each input causes at most one output
// beat and the output is ready; an input that causes more beats holds the back end
// while they are sent, and up to four runs wait in the queue before the input side
// stalls. Results of an accepted input beat are written into the queue and leave
// its head through the back end. Reset (rst_ni, asynchronous, active low) empties
// the window and queue and returns the registers to their reset values at once; no clearing pass.
`timescale 1ns / 1ps
module stream_substring_replace #(
  parameter int MAX_PATTERN     = ssr_pkg::DefMaxPattern,
  parameter int MAX_REPLACEMENT = ssr_pkg::DefMaxReplacement
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ssr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ssr_pkg::CfgDataW-1:0] cfg_wdata_i,
  ssr_in_if.sink                       in_i,
  ssr_out_if.source                    out_o
);

  // The front end keeps the match window and, for every accepted beat, builds one
  // run: the list of output bytes that beat causes. Runs with no bytes are dropped,
  // except at end of stream, where an empty run becomes the empty end marker.
  ssr_pkg::run_t push_run, head_run;
  logic push, q_full, q_valid, pop;

  ssr_front #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .full_i      (q_full),
    .push_o      (push),
    .run_o       (push_run)
  );

  // The queue lets the input keep flowing while a replacement is being expanded.
  ssr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .run_i   (push_run),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .head_o  (head_run)
  );

  // The back end walks the head run one beat at a time and marks its last beat.
  ssr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (head_run),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule
